@@ sv/tcgb_pkg.sv @@
// ----------------------------------------------------------------------------
// Text cell glyph blitter package
// Shared sizes, operation codes, register indexes and the queue item type.
// ----------------------------------------------------------------------------
package tcgb_pkg;

	localparam int GLYPH_W     = 8;
	localparam int GLYPH_H     = 8;
	localparam int NUM_GLYPHS  = 256;
	localparam int CELL_PIX    = GLYPH_W * GLYPH_H;
	localparam int STORE_DEPTH = NUM_GLYPHS * CELL_PIX;
	localparam int STORE_AW    = $clog2(STORE_DEPTH);
	localparam int PIX_W       = $clog2(CELL_PIX);
	localparam int DX_W        = $clog2(GLYPH_W);
	localparam int DY_W        = $clog2(GLYPH_H);

	localparam int Y_W         = $clog2(64 * GLYPH_H);
	localparam int X_W         = $clog2(128 * GLYPH_W);
	localparam int STRIDE_W    = $clog2(256 * GLYPH_W);
	localparam int PROD_W      = Y_W + STRIDE_W;
	localparam int ADDR_W      = 19;

	localparam int S_DATA_W    = 56;
	localparam int S_USER_W    = 2;
	localparam int M_DATA_W    = 32;
	localparam int APB_AW      = 4;
	localparam int APB_DW      = 32;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [1:0] REG_TRANSP = 2'd0;
	localparam logic [1:0] REG_COLS   = 2'd1;
	localparam logic [1:0] REG_ROWS   = 2'd2;

	typedef enum logic [1:0] {
		OP_FONT  = 2'd0,
		OP_STAMP = 2'd1,
		OP_MONO  = 2'd2,
		OP_FILL  = 2'd3
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] glyph;
		logic [5:0] offset;
		logic [7:0] value;
		logic [6:0] col;
		logic [5:0] row;
		logic [7:0] fg;
		logic [7:0] bg;
		logic       glyph_ok;
		logic       on_screen;
	} item_t;

endpackage

@@ sv/tcgb_front.sv @@
// ----------------------------------------------------------------------------
// Glyph blitter front end
// Unpacks input transfers, classifies them and pushes them into the queue.
// ----------------------------------------------------------------------------
module tcgb_front (
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [tcgb_pkg::S_DATA_W-1:0] s_tdata,  // glyph, font_offset, font_value,
	                                                // col, row, fg_color, bg_color
	input  logic [tcgb_pkg::S_USER_W-1:0] s_tuser,  // cmd
	input  logic [7:0]                    screen_cols,
	input  logic [6:0]                    screen_rows,
	input  logic                          full,
	output logic                          push,
	output tcgb_pkg::item_t               push_item
);
	import tcgb_pkg::*;

	item_t item;
	logic  offset_ok;

	always_comb begin
		item.op        = op_t'(s_tuser);
		item.glyph     = s_tdata[7:0];
		item.offset    = s_tdata[13:8];
		item.value     = s_tdata[21:14];
		item.col       = s_tdata[28:22];
		item.row       = s_tdata[34:29];
		item.fg        = s_tdata[42:35];
		item.bg        = s_tdata[50:43];
		item.glyph_ok  = {1'b0, item.glyph} < 9'(NUM_GLYPHS);
		item.on_screen = ({1'b0, item.col} < screen_cols) && ({1'b0, item.row} < screen_rows);
		offset_ok      = {1'b0, item.offset} < 7'(CELL_PIX);
	end

	// Font writes that fall outside the store are taken and dropped here.
	assign s_tready  = !full;
	assign push      = s_tvalid && !full && !(item.op == OP_FONT && !(item.glyph_ok && offset_ok));
	assign push_item = item;

endmodule

@@ sv/tcgb_queue.sv @@
// ----------------------------------------------------------------------------
// Glyph blitter command queue
// Short FIFO that decouples the front end from the drawing back end.
// ----------------------------------------------------------------------------
module tcgb_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  tcgb_pkg::item_t push_item,
	input  logic            pop,
	output logic            full,
	output logic            head_valid,
	output tcgb_pkg::item_t head_item
);
	import tcgb_pkg::*;

	item_t              entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;
	logic               do_push;
	logic               do_pop;

	assign full       = count_q == QCNT_W'(QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head_item  = entries_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
		next_ptr = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

@@ sv/tcgb_back.sv @@
// ----------------------------------------------------------------------------
// Glyph blitter back end
// Owns the glyph store, executes font writes and walks draw cells pixel by
// pixel through a stalling read, address and color pipeline.
// ----------------------------------------------------------------------------
module tcgb_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          head_valid,
	input  tcgb_pkg::item_t               head_item,
	output logic                          pop,
	input  logic [7:0]                    transparent_index,
	input  logic [7:0]                    screen_cols,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [tcgb_pkg::M_DATA_W-1:0] m_tdata,
	output logic                          m_tlast
);
	import tcgb_pkg::*;

	logic [7:0]          store_mem [STORE_DEPTH];

	item_t               cur_q;
	logic                busy_q;
	logic [DX_W-1:0]     dx_q;
	logic [DY_W-1:0]     dy_q;
	logic [PIX_W-1:0]    cnt_q;

	logic                valid_s2;
	logic [7:0]          rd_s2;
	logic [ADDR_W-1:0]   addr_s2;
	logic                last_s2;
	op_t                 op_s2;
	logic [7:0]          fg_s2;
	logic [7:0]          bg_s2;
	logic                ok_s2;
	logic                on_s2;

	logic                out_valid_q;
	logic [ADDR_W-1:0]   out_addr_q;
	logic [7:0]          out_color_q;
	logic                out_we_q;
	logic                out_last_q;

	logic                en;
	logic                issue;
	logic                last_pix;
	logic                font_go;
	logic                draw_go;
	logic [STORE_AW-1:0] waddr;
	logic [STORE_AW-1:0] raddr;
	logic [Y_W-1:0]      y;
	logic [X_W-1:0]      x;
	logic [STRIDE_W-1:0] stride;
	logic [PROD_W-1:0]   prod;
	logic [7:0]          pix;
	logic [7:0]          color;
	logic                we;

	assign en       = !out_valid_q || m_tready;
	assign issue    = busy_q && en;
	assign last_pix = (dx_q == DX_W'(GLYPH_W - 1)) && (dy_q == DY_W'(GLYPH_H - 1));
	assign font_go  = head_valid && (head_item.op == OP_FONT) && !busy_q;
	assign draw_go  = head_valid && (head_item.op != OP_FONT) && (!busy_q || (issue && last_pix));
	assign pop      = font_go || draw_go;

	assign waddr  = STORE_AW'(head_item.glyph) * STORE_AW'(CELL_PIX) + STORE_AW'(head_item.offset);
	assign raddr  = STORE_AW'(cur_q.glyph) * STORE_AW'(CELL_PIX) + STORE_AW'(cnt_q);
	assign y      = Y_W'(cur_q.row) * Y_W'(GLYPH_H) + Y_W'(dy_q);
	assign x      = X_W'(cur_q.col) * X_W'(GLYPH_W) + X_W'(dx_q);
	assign stride = STRIDE_W'(screen_cols) * STRIDE_W'(GLYPH_W);
	assign prod   = PROD_W'(y) * PROD_W'(stride) + PROD_W'(x);

	always_ff @(posedge clk) begin
		if (font_go) begin
			store_mem[waddr] <= head_item.value;
		end
		if (issue) begin
			rd_s2 <= store_mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			dx_q        <= '0;
			dy_q        <= '0;
			cnt_q       <= '0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (draw_go) begin
				busy_q <= 1'b1;
				dx_q   <= '0;
				dy_q   <= '0;
				cnt_q  <= '0;
			end else if (issue) begin
				if (last_pix) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q + 1'b1;
					if (dx_q == DX_W'(GLYPH_W - 1)) begin
						dx_q <= '0;
						dy_q <= dy_q + 1'b1;
					end else begin
						dx_q <= dx_q + 1'b1;
					end
				end
			end
			if (en) begin
				valid_s2    <= issue;
				out_valid_q <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (draw_go) begin
			cur_q <= head_item;
		end
		if (issue) begin
			addr_s2 <= prod[ADDR_W-1:0];
			last_s2 <= last_pix;
			op_s2   <= cur_q.op;
			fg_s2   <= cur_q.fg;
			bg_s2   <= cur_q.bg;
			ok_s2   <= cur_q.glyph_ok;
			on_s2   <= cur_q.on_screen;
		end
		if (en && valid_s2) begin
			out_addr_q  <= addr_s2;
			out_color_q <= color;
			out_we_q    <= we;
			out_last_q  <= last_s2;
		end
	end

	always_comb begin
		pix = ok_s2 ? rd_s2 : transparent_index;
		unique case (op_s2)
			OP_STAMP: begin
				color = pix;
				we    = pix != transparent_index;
			end
			OP_MONO: begin
				color = (pix == transparent_index) ? bg_s2 : fg_s2;
				we    = 1'b1;
			end
			OP_FILL: begin
				color = fg_s2;
				we    = 1'b1;
			end
			default: begin
				color = fg_s2;
				we    = 1'b0;
			end
		endcase
		we = we && on_s2;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(M_DATA_W - ADDR_W - 9){1'b0}}, out_we_q, out_color_q, out_addr_q};
	assign m_tlast  = out_last_q;

endmodule

@@ sv/text_cell_glyph_blitter.sv @@
// ----------------------------------------------------------------------------
// Text cell glyph blitter
// Draws 8 by 8 character cells into an 8-bit indexed framebuffer as a stream
// of pixel writes, from a glyph store loaded by font-write transfers.
// ----------------------------------------------------------------------------
// A draw command (stamp, mono or fill) produces 64 pixel writes, one per cycle
// while the output is ready, in row-major order with tlast on the final one;
// the single port of the 16384-byte glyph store, read once per pixel, sets
// that pace. Consecutive draws follow each other without a gap, and the first
// write of a draw passes through the cell register, the store read stage and
// the output register after its transfer reaches the back end. A font write
// produces no output and runs only when no draw is in progress. The glyph
// store is not cleared at reset: a glyph pixel must be written before any draw reads it.
module text_cell_glyph_blitter (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [tcgb_pkg::S_DATA_W-1:0] s_tdata,  // glyph, font_offset, font_value,
	                                                // col, row, fg_color, bg_color
	input  logic [tcgb_pkg::S_USER_W-1:0] s_tuser,  // cmd
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [tcgb_pkg::M_DATA_W-1:0] m_tdata,  // pixel_addr, pixel_color,
	                                                // write_enable
	output logic                          m_tlast,  // last
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tcgb_pkg::APB_AW-1:0]   paddr,
	input  logic [tcgb_pkg::APB_DW-1:0]   pwdata,
	output logic [tcgb_pkg::APB_DW-1:0]   prdata,
	output logic                          pready
);
	import tcgb_pkg::*;

	logic [7:0] transparent_index_q;
	logic [7:0] screen_cols_q;
	logic [6:0] screen_rows_q;
	logic       cfg_wr;
	logic [1:0] reg_idx;
	logic       full;
	logic       push;
	item_t      push_item;
	logic       pop;
	logic       head_valid;
	item_t      head_item;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			transparent_index_q <= 8'd0;
			screen_cols_q       <= 8'd64;
			screen_rows_q       <= 7'd32;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_TRANSP: transparent_index_q <= pwdata[7:0];
				REG_COLS:   screen_cols_q       <= pwdata[7:0];
				REG_ROWS:   screen_rows_q       <= pwdata[6:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_TRANSP: prdata = APB_DW'(transparent_index_q);
			REG_COLS:   prdata = APB_DW'(screen_cols_q);
			REG_ROWS:   prdata = APB_DW'(screen_rows_q);
			default:    prdata = '0;
		endcase
	end

	tcgb_front u_front (
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.screen_cols (screen_cols_q),
		.screen_rows (screen_rows_q),
		.full        (full),
		.push        (push),
		.push_item   (push_item)
	);

	tcgb_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.pop        (pop),
		.full       (full),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	tcgb_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.head_valid        (head_valid),
		.head_item         (head_item),
		.pop               (pop),
		.transparent_index (transparent_index_q),
		.screen_cols       (screen_cols_q),
		.m_tvalid          (m_tvalid),
		.m_tready          (m_tready),
		.m_tdata           (m_tdata),
		.m_tlast           (m_tlast)
	);

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Text cell glyph blitter testbench
// Loads glyphs, then walks a directed table and several randomized phases of
// font writes and draw commands under changing screen settings and stream
// back-pressure. Every pixel write is compared with a local predictor.
// ----------------------------------------------------------------------------
module testbench;
	import tcgb_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int LONG_HOLD      = 600;
	localparam int SETTLE_CYCLES  = 16;
	localparam int PHASES         = 6;
	localparam int PHASE_ITEMS    = 33;

	typedef struct packed {
		op_t        cmd;
		logic [7:0] glyph;
		logic [5:0] offset;
		logic [7:0] value;
		logic [6:0] col;
		logic [5:0] row;
		logic [7:0] fg;
		logic [7:0] bg;
	} cell_req_t;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [7:0]        color;
		logic              we;
		logic              last;
	} pixel_write_t;

	typedef struct packed {
		cell_req_t         req;
		logic              typed;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        color;
		logic              we;
	} table_row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata = '0;
	logic [S_USER_W-1:0] s_tuser = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;
	logic                m_tlast;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [APB_AW-1:0]   paddr = '0;
	logic [APB_DW-1:0]   pwdata = '0;
	logic [APB_DW-1:0]   prdata;
	logic                pready;

	text_cell_glyph_blitter i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #6 clk = ~clk;

	logic [7:0]          glyph_mem [STORE_DEPTH];
	logic [CELL_PIX-1:0] glyph_loaded [NUM_GLYPHS];
	int                  ready_glyphs [$];
	logic [7:0]          cfg_transp = 8'd0;
	logic [7:0]          cfg_cols = 8'd64;
	logic [6:0]          cfg_rows = 7'd32;
	pixel_write_t        expected_writes [$];
	table_row_t          directed [$];
	int                  failures = 0;
	int                  writes_seen = 0;
	int                  quiet_cycles = 0;
	int                  send_idle_pct = 0;
	int                  ready_stall_pct = 0;
	int                  long_hold_req = 0;
	int                  hold_seen;
	int                  hold_left;

	initial begin
		for (int g = 0; g < NUM_GLYPHS; g++) begin
			glyph_loaded[g] = '0;
		end
	end

	function automatic void log_failure(input string msg);
		if (failures < 10) begin
			$display("%s", msg);
		end
		failures++;
	endfunction

	function automatic void predict_cell(input cell_req_t r);
		int stride;
		int a;
		logic [7:0] pix;
		logic [7:0] color;
		logic we;
		logic on_scr;
		pixel_write_t w;
		if (r.cmd == OP_FONT) begin
			glyph_mem[r.glyph * CELL_PIX + r.offset] = r.value;
			return;
		end
		stride = cfg_cols * GLYPH_W;
		on_scr = (r.col < cfg_cols) && (r.row < cfg_rows);
		for (int dy = 0; dy < GLYPH_H; dy++) begin
			for (int dx = 0; dx < GLYPH_W; dx++) begin
				a = (r.row * GLYPH_H + dy) * stride + r.col * GLYPH_W + dx;
				pix = glyph_mem[r.glyph * CELL_PIX + dy * GLYPH_W + dx];
				case (r.cmd)
					OP_STAMP: begin
						color = pix;
						we = (pix != cfg_transp);
					end
					OP_MONO: begin
						color = (pix == cfg_transp) ? r.bg : r.fg;
						we = 1'b1;
					end
					default: begin
						color = r.fg;
						we = 1'b1;
					end
				endcase
				w.addr = a[ADDR_W-1:0];
				w.color = color;
				w.we = we & on_scr;
				w.last = (dy == GLYPH_H - 1) && (dx == GLYPH_W - 1);
				expected_writes.push_back(w);
			end
		end
	endfunction

	function automatic table_row_t table_row(input op_t c, input logic [7:0] g,
			input logic [5:0] off, input logic [7:0] v, input logic [6:0] col,
			input logic [5:0] row, input logic [7:0] fg, input logic [7:0] bg,
			input logic typed, input logic [ADDR_W-1:0] a, input logic [7:0] color,
			input logic we);
		table_row_t t;
		t.req = '{cmd: c, glyph: g, offset: off, value: v, col: col, row: row,
			fg: fg, bg: bg};
		t.typed = typed;
		t.addr = a;
		t.color = color;
		t.we = we;
		return t;
	endfunction

	function automatic logic [7:0] pick_shade();
		case ($urandom_range(9))
			0, 1, 2: return cfg_transp;
			3:       return 8'h00;
			4:       return 8'hFF;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	function automatic cell_req_t random_req();
		cell_req_t r;
		int lim;
		r.glyph = 8'(ready_glyphs[$urandom_range(ready_glyphs.size() - 1)]);
		r.offset = 6'($urandom_range(63));
		r.value = pick_shade();
		r.fg = 8'($urandom_range(255));
		r.bg = 8'($urandom_range(255));
		r.col = 7'($urandom_range(127));
		r.row = 6'($urandom_range(63));
		if ($urandom_range(9) < 3) begin
			r.cmd = OP_FONT;
			if ($urandom_range(1) == 1) begin
				r.glyph = 8'($urandom_range(255));
			end
		end else begin
			r.cmd = op_t'($urandom_range(3, 1));
			if ($urandom_range(1) == 1) begin
				if (cfg_cols != 0) begin
					lim = (cfg_cols > 128) ? 127 : cfg_cols - 1;
					r.col = 7'($urandom_range(lim));
				end
				if (cfg_rows != 0) begin
					lim = (cfg_rows > 64) ? 63 : cfg_rows - 1;
					r.row = 6'($urandom_range(lim));
				end
			end
		end
		return r;
	endfunction

	task automatic send_cell(input cell_req_t r, input logic typed = 1'b0,
			input logic [ADDR_W-1:0] t_addr = '0, input logic [7:0] t_color = '0,
			input logic t_we = 1'b0);
		int first;
		first = expected_writes.size();
		predict_cell(r);
		if (typed) begin
			expected_writes[first].addr = t_addr;
			expected_writes[first].color = t_color;
			expected_writes[first].we = t_we;
		end
		if (r.cmd == OP_FONT && !(&glyph_loaded[r.glyph])) begin
			glyph_loaded[r.glyph][r.offset] = 1'b1;
			if (&glyph_loaded[r.glyph]) begin
				ready_glyphs.push_back(r.glyph);
			end
		end
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= r.cmd;
		s_tdata <= {5'b0, r.bg, r.fg, r.row, r.col, r.value, r.offset, r.glyph};
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		while (expected_writes.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic reg_write(input logic [1:0] idx, input logic [APB_DW-1:0] val);
		logic [APB_DW-1:0] want;
		want = (idx == REG_ROWS) ? (val & 32'h7F) : (val & 32'hFF);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		case (idx)
			REG_TRANSP: cfg_transp = val[7:0];
			REG_COLS:   cfg_cols = val[7:0];
			default:    cfg_rows = val[6:0];
		endcase
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== want) begin
			log_failure($sformatf("register %0d read %h, expected %h", idx, prdata, want));
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold_left <= 0;
			hold_seen <= 0;
		end else if (hold_seen != long_hold_req) begin
			hold_seen <= long_hold_req;
			hold_left <= LONG_HOLD;
			m_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= ready_stall_pct);
		end
	end

	always @(posedge clk) begin : pixel_monitor
		pixel_write_t seen;
		pixel_write_t want;
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (m_tvalid && m_tready) begin
				seen.addr = m_tdata[18:0];
				seen.color = m_tdata[26:19];
				seen.we = m_tdata[27];
				seen.last = m_tlast;
				if (expected_writes.size() == 0) begin
					log_failure($sformatf("pixel write %0d arrived with nothing expected",
						writes_seen));
				end else begin
					want = expected_writes.pop_front();
					if (seen !== want) begin
						log_failure($sformatf(
							"pixel write %0d: expected addr %h color %h we %b last %b, got addr %h color %h we %b last %b",
							writes_seen, want.addr, want.color, want.we, want.last,
							seen.addr, seen.color, seen.we, seen.last));
					end
				end
				writes_seen++;
			end
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	initial begin
		cell_req_t r;
		logic [7:0] preload [4];
		preload = '{8'h00, 8'hFF, 8'h5A, 8'hA5};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Load a few glyphs completely, so that draws only touch written pixels.
		foreach (preload[i]) begin
			for (int off = 0; off < CELL_PIX; off++) begin
				r = '{cmd: OP_FONT, glyph: preload[i], offset: 6'(off),
					value: pick_shade(), col: '0, row: '0, fg: '0, bg: '0};
				send_cell(r);
			end
		end

		directed.push_back(table_row(OP_FONT, 8'h00, 6'd0, 8'h00, 7'd0, 6'd0, 8'h00, 8'h00,
			1'b0, '0, '0, 1'b0));
		directed.push_back(table_row(OP_FONT, 8'hFF, 6'd63, 8'hFF, 7'd127, 6'd63, 8'hFF,
			8'hFF, 1'b0, '0, '0, 1'b0));
		directed.push_back(table_row(OP_FONT, 8'h5A, 6'd42, 8'h7E, 7'd0, 6'd0, 8'h00, 8'h00,
			1'b0, '0, '0, 1'b0));
		directed.push_back(table_row(OP_FILL, 8'h00, 6'd0, 8'h00, 7'd0, 6'd0, 8'hFF, 8'h00,
			1'b1, 19'd0, 8'hFF, 1'b1));
		directed.push_back(table_row(OP_FILL, 8'hFF, 6'd0, 8'h00, 7'd63, 6'd31, 8'h00, 8'hFF,
			1'b1, 19'd127480, 8'h00, 1'b1));
		directed.push_back(table_row(OP_FILL, 8'h00, 6'd0, 8'h00, 7'd64, 6'd0, 8'h3C, 8'h00,
			1'b1, 19'd512, 8'h3C, 1'b0));
		directed.push_back(table_row(OP_FILL, 8'h00, 6'd0, 8'h00, 7'd0, 6'd32, 8'hC3, 8'h00,
			1'b1, 19'd131072, 8'hC3, 1'b0));
		directed.push_back(table_row(OP_FILL, 8'h00, 6'd0, 8'h00, 7'd127, 6'd63, 8'h81,
			8'h00, 1'b1, 19'd259064, 8'h81, 1'b0));
		directed.push_back(table_row(OP_STAMP, 8'h00, 6'd0, 8'h00, 7'd0, 6'd0, 8'h00, 8'h00,
			1'b1, 19'd0, 8'h00, 1'b0));
		directed.push_back(table_row(OP_MONO, 8'h00, 6'd0, 8'h00, 7'd1, 6'd1, 8'hAA, 8'h55,
			1'b1, 19'd4104, 8'h55, 1'b1));
		directed.push_back(table_row(OP_STAMP, 8'hFF, 6'd0, 8'h00, 7'd5, 6'd7, 8'h00, 8'h00,
			1'b0, '0, '0, 1'b0));
		directed.push_back(table_row(OP_MONO, 8'hFF, 6'd0, 8'h00, 7'd63, 6'd31, 8'h11, 8'hEE,
			1'b0, '0, '0, 1'b0));
		directed.push_back(table_row(OP_MONO, 8'h5A, 6'd0, 8'h00, 7'd100, 6'd40, 8'hF0,
			8'h0F, 1'b0, '0, '0, 1'b0));
		directed.push_back(table_row(OP_FONT, 8'h5A, 6'd0, 8'h99, 7'd0, 6'd0, 8'h00, 8'h00,
			1'b0, '0, '0, 1'b0));
		directed.push_back(table_row(OP_MONO, 8'h5A, 6'd0, 8'h00, 7'd0, 6'd0, 8'h12, 8'h34,
			1'b1, 19'd0, 8'h12, 1'b1));
		directed.push_back(table_row(OP_FONT, 8'hA5, 6'd0, 8'h00, 7'd0, 6'd0, 8'h00, 8'h00,
			1'b0, '0, '0, 1'b0));
		directed.push_back(table_row(OP_STAMP, 8'hA5, 6'd0, 8'h00, 7'd2, 6'd3, 8'h00, 8'h00,
			1'b1, 19'd12304, 8'h00, 1'b0));
		directed.push_back(table_row(OP_STAMP, 8'h5A, 6'd0, 8'h00, 7'd127, 6'd0, 8'h00,
			8'h00, 1'b0, '0, '0, 1'b0));
		directed.push_back(table_row(OP_FILL, 8'hA5, 6'd0, 8'h00, 7'd10, 6'd10, 8'h5A, 8'hA5,
			1'b0, '0, '0, 1'b0));
		foreach (directed[i]) begin
			send_cell(directed[i].req, directed[i].typed, directed[i].addr,
				directed[i].color, directed[i].we);
		end
		settle();

		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: begin
					reg_write(REG_TRANSP, 32'h00);
					reg_write(REG_COLS, 32'd1);
					reg_write(REG_ROWS, 32'd1);
				end
				1: begin
					reg_write(REG_TRANSP, 32'hFF);
					reg_write(REG_COLS, 32'd128);
					reg_write(REG_ROWS, 32'd64);
				end
				2: begin
					reg_write(REG_TRANSP, $urandom_range(255));
					reg_write(REG_COLS, $urandom_range(128, 1));
					reg_write(REG_ROWS, $urandom_range(64, 1));
				end
				3: begin
					reg_write(REG_TRANSP, $urandom_range(255));
					reg_write(REG_COLS, 32'd255);
					reg_write(REG_ROWS, 32'd127);
				end
				4: begin
					reg_write(REG_TRANSP, $urandom_range(255));
					reg_write(REG_COLS, 32'd0);
					reg_write(REG_ROWS, 32'd0);
				end
				default: begin
					reg_write(REG_TRANSP, $urandom_range(255));
					reg_write(REG_COLS, 32'd80);
					reg_write(REG_ROWS, 32'd25);
				end
			endcase
			case (phase % 4)
				0: begin
					send_idle_pct = 0;
					ready_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 82;
					ready_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					ready_stall_pct = 82;
				end
				default: begin
					send_idle_pct = 8;
					ready_stall_pct = 8;
				end
			endcase
			@(posedge clk);
			if (phase == 0) begin
				long_hold_req <= long_hold_req + 1;
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				send_cell(random_req());
			end
			settle();
		end

		repeat (2 * SETTLE_CYCLES) @(posedge clk);
		if (failures == 0 && expected_writes.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
